/* rtl/vcsg_pkg.sv */
`timescale 1ns / 1ps

package vcsg_pkg;

	// Item codes
	localparam int CMD_W = 3;
	localparam logic [CMD_W-1:0] CMD_TICK         = 3'd0;
	localparam logic [CMD_W-1:0] CMD_SOURCE       = 3'd1;
	localparam logic [CMD_W-1:0] CMD_ARM_STATUS   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_EGRESS_START = 3'd3;
	localparam logic [CMD_W-1:0] CMD_EGRESS_STOP  = 3'd4;

	// Field widths
	localparam int VEL_W   = 16;
	localparam int LIM_W   = 15;
	localparam int MS_W    = 16;
	localparam int STAMP_W = 32;
	localparam int IDENT_W = 32;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_TIMEOUT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REQUIRE_STOWED = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STATUS_TIMEOUT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LIN_SPEED  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_TURN_RATE  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LIN_ACCEL  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_TURN_ACCEL = 3'd6;

	// Register reset values
	localparam logic [MS_W-1:0]  RST_SOURCE_TIMEOUT = 16'd200;
	localparam logic [MS_W-1:0]  RST_STATUS_TIMEOUT = 16'd200;
	localparam logic [LIM_W-1:0] RST_MAX_LIN_SPEED  = 15'd500;
	localparam logic [LIM_W-1:0] RST_MAX_TURN_RATE  = 15'd400;
	localparam logic [MS_W-1:0]  RST_MAX_LIN_ACCEL  = 16'd500;
	localparam logic [MS_W-1:0]  RST_MAX_TURN_ACCEL = 16'd400;

	// Saturation points
	localparam logic [MS_W-1:0] ELAPSED_MAX = 16'hFFFF;
	localparam logic [MS_W-1:0] CHANGE_MAX  = 16'hFFFF;

	// floor(p / 1000) = (p * 274877907) >> 38, exact for all p below 2^32
	localparam int PROD_W      = 32;
	localparam int RECIP_W     = 29;
	localparam int RECIP_SHIFT = 38;
	localparam int FULL_W      = PROD_W + RECIP_W;
	localparam int QUOT_W      = FULL_W - RECIP_SHIFT;
	localparam logic [RECIP_W-1:0] DIV1000_MUL = 29'd274877907;

	typedef struct packed {
		logic [MS_W-1:0]  source_timeout;
		logic             require_stowed;
		logic [MS_W-1:0]  status_timeout;
		logic [LIM_W-1:0] max_lin_speed;
		logic [LIM_W-1:0] max_turn_rate;
		logic [MS_W-1:0]  max_lin_accel;
		logic [MS_W-1:0]  max_turn_accel;
	} cfg_t;

endpackage

/* rtl/vcsg_in_if.sv */
`timescale 1ns / 1ps

// Input channel: one event word per handshake
interface vcsg_in_if;
	logic                                 valid;
	logic                                 ready;
	logic [vcsg_pkg::CMD_W-1:0]           command;
	logic [vcsg_pkg::STAMP_W-1:0]         time_ms;
	logic signed [vcsg_pkg::VEL_W-1:0]    linear_command;
	logic signed [vcsg_pkg::VEL_W-1:0]    angular_command;
	logic                                 command_planar_ok;
	logic [vcsg_pkg::IDENT_W-1:0]         status_boot_id;
	logic [vcsg_pkg::IDENT_W-1:0]         status_sequence;
	logic                                 status_semantics_ok;
	logic [vcsg_pkg::LIM_W-1:0]           egress_speed_in;

	modport source (
		output valid, command, time_ms, linear_command, angular_command,
			command_planar_ok, status_boot_id, status_sequence,
			status_semantics_ok, egress_speed_in,
		input  ready
	);
	modport sink (
		input  valid, command, time_ms, linear_command, angular_command,
			command_planar_ok, status_boot_id, status_sequence,
			status_semantics_ok, egress_speed_in,
		output ready
	);
endinterface

/* rtl/vcsg_out_if.sv */
`timescale 1ns / 1ps

// Output channel: one published velocity word per handshake
interface vcsg_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [vcsg_pkg::VEL_W-1:0] linear_out;
	logic signed [vcsg_pkg::VEL_W-1:0] angular_out;

	modport source (output valid, linear_out, angular_out, input ready);
	modport sink   (input valid, linear_out, angular_out, output ready);
endinterface

/* rtl/vcsg_cfg_regs.sv */
`timescale 1ns / 1ps

module vcsg_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [vcsg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [vcsg_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	output vcsg_pkg::cfg_t                   cfg
);
	import vcsg_pkg::*;

	cfg_t cfg_q;

	// Register file, writes to unused indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.source_timeout <= RST_SOURCE_TIMEOUT;
			cfg_q.require_stowed <= 1'b0;
			cfg_q.status_timeout <= RST_STATUS_TIMEOUT;
			cfg_q.max_lin_speed  <= RST_MAX_LIN_SPEED;
			cfg_q.max_turn_rate  <= RST_MAX_TURN_RATE;
			cfg_q.max_lin_accel  <= RST_MAX_LIN_ACCEL;
			cfg_q.max_turn_accel <= RST_MAX_TURN_ACCEL;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_SOURCE_TIMEOUT: cfg_q.source_timeout <= cfg_wdata[MS_W-1:0];
				REG_REQUIRE_STOWED: cfg_q.require_stowed <= cfg_wdata[0];
				REG_STATUS_TIMEOUT: cfg_q.status_timeout <= cfg_wdata[MS_W-1:0];
				REG_MAX_LIN_SPEED:  cfg_q.max_lin_speed  <= cfg_wdata[LIM_W-1:0];
				REG_MAX_TURN_RATE:  cfg_q.max_turn_rate  <= cfg_wdata[LIM_W-1:0];
				REG_MAX_LIN_ACCEL:  cfg_q.max_lin_accel  <= cfg_wdata[MS_W-1:0];
				REG_MAX_TURN_ACCEL: cfg_q.max_turn_accel <= cfg_wdata[MS_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* rtl/vcsg_slew.sv */
`timescale 1ns / 1ps

// One axis of the slew limiter: step limit from accel*elapsed, then a
// clamped move from the current value towards the target.
module vcsg_slew (
	input  logic [vcsg_pkg::PROD_W-1:0]       product,
	input  logic signed [vcsg_pkg::VEL_W-1:0] target,
	input  logic signed [vcsg_pkg::VEL_W-1:0] current,
	output logic signed [vcsg_pkg::VEL_W-1:0] result
);
	import vcsg_pkg::*;

	localparam int DIFF_W = VEL_W + 2;

	logic [FULL_W-1:0]        full;
	logic [QUOT_W-1:0]        quot;
	logic [MS_W-1:0]          step_lim;
	logic signed [DIFF_W-1:0] diff;
	logic signed [DIFF_W-1:0] lim_pos;
	logic signed [DIFF_W-1:0] lim_neg;
	logic signed [DIFF_W-1:0] step;
	logic signed [DIFF_W-1:0] sum;

	// Divide by 1000 through the reciprocal, saturate the step
	assign full     = FULL_W'(product) * FULL_W'(DIV1000_MUL);
	assign quot     = full[FULL_W-1:RECIP_SHIFT];
	assign step_lim = ((quot >> MS_W) != '0) ? CHANGE_MAX : quot[MS_W-1:0];

	// Clamp the difference to +/- step limit
	always_comb begin
		diff    = DIFF_W'(target) - DIFF_W'(current);
		lim_pos = signed'({2'b00, step_lim});
		lim_neg = -lim_pos;
		if (diff > lim_pos) begin
			step = lim_pos;
		end else if (diff < lim_neg) begin
			step = lim_neg;
		end else begin
			step = diff;
		end
		sum = DIFF_W'(current) + step;
	end

	assign result = signed'(sum[VEL_W-1:0]);

endmodule

/* rtl/velocity_command_safety_gate.sv */
`timescale 1ns / 1ps

// Safety gate for a two-axis velocity command.
// cmd carries event words (tick, source command, arm status, egress start,
// egress stop) with a millisecond timestamp; vel carries published
// linear/angular velocities. A word is moved when valid and ready are high.
// Registers are written through cfg_wr_en/cfg_index/cfg_wdata; the user
// must write them only while the block is idle (not enforced by the block).
// Throughput: one event word per cycle unless a word with a result meets
// a stalled receiver. Each accepted word sits in the input register, where
// its state update, clamp and slew are done; any result goes on to the
// output register. The accel*elapsed product is formed as the word enters;
// the divide by 1000 (a reciprocal multiply) and the clamp follow there.
// Reset clears gate state and valid flags, loads register defaults; no clearing pass.
// If the receiver stalls with a result pending, the input register holds
// the next word and cmd.ready drops only once that word also has a result
// to deliver; words that give no result keep flowing.
module velocity_command_safety_gate #(
	parameter int TIME_BITS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	vcsg_in_if.sink                         cmd,
	vcsg_out_if.source                      vel,
	input  logic                            cfg_wr_en,
	input  logic [vcsg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [vcsg_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import vcsg_pkg::*;

	cfg_t cfg;

	// Input register
	logic                    valid_s1;
	logic [CMD_W-1:0]        command_s1;
	logic [TIME_BITS-1:0]    now_s1;
	logic signed [VEL_W-1:0] lin_cmd_s1;
	logic signed [VEL_W-1:0] ang_cmd_s1;
	logic                    planar_ok_s1;
	logic [IDENT_W-1:0]      boot_s1;
	logic [IDENT_W-1:0]      seq_s1;
	logic                    sem_ok_s1;
	logic [LIM_W-1:0]        egress_speed_s1;
	logic [PROD_W-1:0]       p_lin_s1;
	logic [PROD_W-1:0]       p_ang_s1;

	// Gate state
	logic                    have_source_q;
	logic                    source_ok_q;
	logic                    source_active_q;
	logic signed [VEL_W-1:0] held_linear_q;
	logic signed [VEL_W-1:0] held_angular_q;
	logic [TIME_BITS-1:0]    source_time_q;
	logic                    have_status_q;
	logic                    status_ok_q;
	logic [IDENT_W-1:0]      stored_boot_q;
	logic [IDENT_W-1:0]      stored_seq_q;
	logic [TIME_BITS-1:0]    status_time_q;
	logic                    egress_active_q;
	logic [LIM_W-1:0]        egress_speed_q;
	logic signed [VEL_W-1:0] prev_linear_q;
	logic signed [VEL_W-1:0] prev_angular_q;
	logic [TIME_BITS-1:0]    output_time_q;
	logic [TIME_BITS-1:0]    suppress_until_q;
	logic                    suppress_valid_q;

	// Output register
	logic                    vel_valid_q;
	logic signed [VEL_W-1:0] vel_lin_q;
	logic signed [VEL_W-1:0] vel_ang_q;

	logic                    is_tick;
	logic                    is_start;
	logic                    is_stop;
	logic                    fire;
	logic                    go;
	logic                    res_n;
	logic signed [VEL_W-1:0] res_lin;
	logic signed [VEL_W-1:0] res_ang;
	logic                    allowed;
	logic                    suppressed;
	logic                    seq_ok;
	logic [TIME_BITS-1:0]    ahead;
	logic signed [VEL_W-1:0] tgt_lin;
	logic signed [VEL_W-1:0] tgt_ang;
	logic signed [VEL_W-1:0] slew_lin;
	logic signed [VEL_W-1:0] slew_ang;
	logic [TIME_BITS-1:0]    now_in;
	logic [TIME_BITS-1:0]    out_time_nx;
	logic [TIME_BITS-1:0]    el_diff;
	logic [MS_W-1:0]         el_in;
	logic [PROD_W-1:0]       p_lin_in;
	logic [PROD_W-1:0]       p_ang_in;

	function automatic logic age_ok(input logic [TIME_BITS-1:0] age,
			input logic [MS_W-1:0] lim);
		return ((age >> MS_W) == '0) && (age[MS_W-1:0] <= lim);
	endfunction

	function automatic logic signed [VEL_W-1:0] clamp_lim(
			input logic signed [VEL_W-1:0] v, input logic [LIM_W-1:0] lim);
		logic signed [VEL_W-1:0] hi;
		logic signed [VEL_W-1:0] lo;
		hi = signed'({1'b0, lim});
		lo = -hi;
		if (v > hi) return hi;
		if (v < lo) return lo;
		return v;
	endfunction

	vcsg_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Entry: elapsed time against the output time as the word in flight
	// leaves it, then accel * elapsed per axis
	assign now_in      = TIME_BITS'(cmd.time_ms);
	assign out_time_nx = (fire && (is_tick || (is_start && !egress_active_q))) ?
		now_s1 : output_time_q;
	assign el_diff     = now_in - out_time_nx;
	assign el_in       = ((el_diff >> MS_W) != '0) ? ELAPSED_MAX : el_diff[MS_W-1:0];
	assign p_lin_in    = PROD_W'(cfg.max_lin_accel) * PROD_W'(el_in);
	assign p_ang_in    = PROD_W'(cfg.max_turn_accel) * PROD_W'(el_in);

	// Handshake
	assign go        = !res_n || !vel_valid_q || vel.ready;
	assign fire      = valid_s1 && go;
	assign cmd.ready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready) begin
			command_s1      <= cmd.command;
			now_s1          <= now_in;
			lin_cmd_s1      <= cmd.linear_command;
			ang_cmd_s1      <= cmd.angular_command;
			planar_ok_s1    <= cmd.command_planar_ok;
			boot_s1         <= cmd.status_boot_id;
			seq_s1          <= cmd.status_sequence;
			sem_ok_s1       <= cmd.status_semantics_ok;
			egress_speed_s1 <= cmd.egress_speed_in;
			p_lin_s1        <= p_lin_in;
			p_ang_s1        <= p_ang_in;
		end
	end

	// Decode and checks
	assign is_tick   = (command_s1 == CMD_TICK);
	assign is_start  = (command_s1 == CMD_EGRESS_START);
	assign is_stop   = (command_s1 == CMD_EGRESS_STOP);

	assign allowed = have_source_q && source_ok_q &&
		age_ok(now_s1 - source_time_q, cfg.source_timeout) &&
		(!cfg.require_stowed || (have_status_q && status_ok_q &&
		age_ok(now_s1 - status_time_q, cfg.status_timeout)));

	assign ahead      = suppress_until_q - now_s1;
	assign suppressed = suppress_valid_q && (ahead != '0) && ((ahead >> MS_W) == '0);

	assign seq_ok = (boot_s1 != '0) && (seq_s1 != '0) &&
		!(have_status_q && (boot_s1 == stored_boot_q) && (seq_s1 <= stored_seq_q));

	// Slew targets: reverse egress speed with no turn, else clamped command
	assign tgt_lin = egress_active_q ? -signed'({1'b0, egress_speed_q}) :
		clamp_lim(held_linear_q, cfg.max_lin_speed);
	assign tgt_ang = egress_active_q ? '0 : clamp_lim(held_angular_q, cfg.max_turn_rate);

	vcsg_slew u_slew_lin (
		.product (p_lin_s1),
		.target  (tgt_lin),
		.current (prev_linear_q),
		.result  (slew_lin)
	);

	vcsg_slew u_slew_ang (
		.product (p_ang_s1),
		.target  (tgt_ang),
		.current (prev_angular_q),
		.result  (slew_ang)
	);

	// Result selection
	always_comb begin
		res_n   = 1'b0;
		res_lin = '0;
		res_ang = '0;
		if (valid_s1 && is_tick) begin
			if (egress_active_q || allowed) begin
				res_n   = 1'b1;
				res_lin = slew_lin;
				res_ang = slew_ang;
			end else if (source_active_q) begin
				res_n = 1'b1;
			end
		end else if (valid_s1 && is_stop && egress_active_q) begin
			res_n = 1'b1;
		end
	end

	// State update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_source_q    <= 1'b0;
			source_ok_q      <= 1'b0;
			source_active_q  <= 1'b0;
			held_linear_q    <= '0;
			held_angular_q   <= '0;
			source_time_q    <= '0;
			have_status_q    <= 1'b0;
			status_ok_q      <= 1'b0;
			stored_boot_q    <= '0;
			stored_seq_q     <= '0;
			status_time_q    <= '0;
			egress_active_q  <= 1'b0;
			egress_speed_q   <= '0;
			prev_linear_q    <= '0;
			prev_angular_q   <= '0;
			output_time_q    <= '0;
			suppress_until_q <= '0;
			suppress_valid_q <= 1'b0;
		end else if (fire) begin
			case (command_s1)
				CMD_TICK: begin
					if (egress_active_q) begin
						prev_linear_q  <= slew_lin;
						prev_angular_q <= slew_ang;
					end else if (allowed) begin
						prev_linear_q   <= slew_lin;
						prev_angular_q  <= slew_ang;
						source_active_q <= 1'b1;
					end else if (source_active_q) begin
						source_active_q <= 1'b0;
						prev_linear_q   <= '0;
						prev_angular_q  <= '0;
					end
					output_time_q <= now_s1;
				end
				CMD_SOURCE: begin
					if (!egress_active_q && !suppressed) begin
						held_linear_q  <= lin_cmd_s1;
						held_angular_q <= ang_cmd_s1;
						source_ok_q    <= planar_ok_s1;
						have_source_q  <= 1'b1;
						source_time_q  <= now_s1;
					end
				end
				CMD_ARM_STATUS: begin
					have_status_q <= 1'b1;
					status_time_q <= now_s1;
					status_ok_q   <= seq_ok && sem_ok_s1;
					if (seq_ok) begin
						stored_boot_q <= boot_s1;
						stored_seq_q  <= seq_s1;
					end
				end
				CMD_EGRESS_START: begin
					if (!egress_active_q) begin
						egress_active_q <= 1'b1;
						egress_speed_q  <= egress_speed_s1;
						source_active_q <= 1'b0;
						have_source_q   <= 1'b0;
						source_ok_q     <= 1'b0;
						prev_linear_q   <= '0;
						prev_angular_q  <= '0;
						output_time_q   <= now_s1;
					end
				end
				CMD_EGRESS_STOP: begin
					if (egress_active_q) begin
						egress_active_q  <= 1'b0;
						source_active_q  <= 1'b0;
						have_source_q    <= 1'b0;
						source_ok_q      <= 1'b0;
						prev_linear_q    <= '0;
						prev_angular_q   <= '0;
						suppress_until_q <= now_s1 + TIME_BITS'(cfg.source_timeout);
						suppress_valid_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vel_valid_q <= 1'b0;
		end else if (fire && res_n) begin
			vel_valid_q <= 1'b1;
		end else if (vel.ready) begin
			vel_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res_n) begin
			vel_lin_q <= res_lin;
			vel_ang_q <= res_ang;
		end
	end

	assign vel.valid       = vel_valid_q;
	assign vel.linear_out  = vel_lin_q;
	assign vel.angular_out = vel_ang_q;

endmodule
